@@ src/wma_pkg.sv @@
// Package for the windowed moving average block.
// Holds the shared widths, the queue entry type and the divider state type.
// Depends on nothing.
`default_nettype none
package wma_pkg;

  localparam int MAX_WINDOW  = 8;
  localparam int IDX_W       = $clog2(MAX_WINDOW);
  localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = 20;
  localparam int LEN_W       = 4;
  localparam int STEP_W      = $clog2(SUM_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LEN_W-1:0] LEN_RESET = 4'd5;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
  } wma_job_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } wma_div_state_t;

endpackage
`default_nettype wire

@@ src/wma_front.sv @@
// Front part: accepts samples, keeps the sample ring, fill count and running sum.
// Emits one sum and count job per item. Depends on wma_pkg.
`default_nettype none
module wma_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [wma_pkg::LEN_W-1:0]           cfg_window_len,
  input  wire logic                                in_valid,
  input  wire logic signed [wma_pkg::SAMPLE_W-1:0] in_sample,
  output wma_pkg::wma_job_t                        job
);

  logic [wma_pkg::LEN_W-1:0]           len_r;
  logic [wma_pkg::IDX_W-1:0]           oldest_r, oldest_nxt;
  logic [wma_pkg::CNT_W-1:0]           fill_r, fill_nxt;
  logic signed [wma_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic signed [wma_pkg::SAMPLE_W-1:0] ring_r [wma_pkg::MAX_WINDOW];

  logic [wma_pkg::CNT_W-1:0]        eff_len;
  logic                             win_full;
  logic [wma_pkg::IDX_W-1:0]        slot;
  logic signed [wma_pkg::SUM_W-1:0] drop_val;

  always_comb begin
    if (len_r == '0) begin
      eff_len = wma_pkg::CNT_W'(1);
    end else if (int'(len_r) > wma_pkg::MAX_WINDOW) begin
      eff_len = wma_pkg::CNT_W'(wma_pkg::MAX_WINDOW);
    end else begin
      eff_len = wma_pkg::CNT_W'(len_r);
    end
  end

  always_comb begin
    win_full = (fill_r == eff_len);
    slot     = win_full ? oldest_r : fill_r[wma_pkg::IDX_W-1:0];
    drop_val = win_full ? wma_pkg::SUM_W'(ring_r[oldest_r]) : '0;
    sum_nxt  = sum_r - drop_val + wma_pkg::SUM_W'(in_sample);
    if (win_full) begin
      fill_nxt = fill_r;
      if (wma_pkg::CNT_W'(oldest_r) == eff_len - wma_pkg::CNT_W'(1)) begin
        oldest_nxt = '0;
      end else begin
        oldest_nxt = oldest_r + wma_pkg::IDX_W'(1);
      end
    end else begin
      fill_nxt   = fill_r + wma_pkg::CNT_W'(1);
      oldest_nxt = oldest_r;
    end
  end

  assign job.sum   = sum_nxt;
  assign job.count = fill_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= wma_pkg::LEN_RESET;
      oldest_r <= '0;
      fill_r   <= '0;
      sum_r    <= '0;
    end else if (cfg_we) begin
      len_r    <= cfg_window_len;
      oldest_r <= '0;
      fill_r   <= '0;
      sum_r    <= '0;
    end else if (in_valid) begin
      oldest_r <= oldest_nxt;
      fill_r   <= fill_nxt;
      sum_r    <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      ring_r[slot] <= in_sample;
    end
  end

endmodule
`default_nettype wire

@@ src/wma_queue.sv @@
// Short job queue between the front part and the divider.
// Depends on wma_pkg.
`default_nettype none
module wma_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire wma_pkg::wma_job_t wr_job,
  output logic                   q_full,
  output logic                   head_valid,
  output wma_pkg::wma_job_t      head_job,
  input  wire logic              rd_en
);

  wma_pkg::wma_job_t             mem_r [wma_pkg::QUEUE_DEPTH];
  logic [wma_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [wma_pkg::QCNT_W-1:0]    cnt_r;
  logic                          do_wr, do_rd;

  assign q_full     = (cnt_r == wma_pkg::QCNT_W'(wma_pkg::QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_wr      = wr_en && !q_full;
  assign do_rd      = rd_en && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + wma_pkg::QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + wma_pkg::QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + wma_pkg::QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - wma_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule
`default_nettype wire

@@ src/wma_back.sv @@
// Back part: bit-serial restoring divide of the window sum by the count,
// truncated toward zero, with a one-entry result register. Depends on wma_pkg.
`default_nettype none
module wma_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          head_valid,
  input  wire wma_pkg::wma_job_t             head_job,
  output logic                               head_pop,
  output logic                               empty,
  input  wire logic                          pop,
  output logic signed [wma_pkg::SAMPLE_W-1:0] out_average
);

  wma_pkg::wma_div_state_t state_r, state_nxt;

  logic [wma_pkg::SUM_W-1:0]           quo_r, quo_nxt;
  logic [wma_pkg::CNT_W-1:0]           rem_r, rem_nxt;
  logic [wma_pkg::CNT_W-1:0]           div_r;
  logic                                neg_r;
  logic [wma_pkg::STEP_W-1:0]          step_r;
  logic signed [wma_pkg::SAMPLE_W-1:0] avg_r;
  logic                                out_valid_r;

  logic                                out_load;
  logic                                last_step;
  logic [wma_pkg::CNT_W:0]             shifted;
  logic                                ge;
  logic [wma_pkg::SUM_W-1:0]           mag;
  logic [wma_pkg::SAMPLE_W-1:0]        q16;

  assign last_step = (step_r == wma_pkg::STEP_W'(wma_pkg::SUM_W - 1));

  always_comb begin
    shifted = {rem_r, quo_r[wma_pkg::SUM_W-1]};
    ge      = (shifted >= {1'b0, div_r});
    rem_nxt = ge ? wma_pkg::CNT_W'(shifted - {1'b0, div_r})
                 : wma_pkg::CNT_W'(shifted);
    quo_nxt = {quo_r[wma_pkg::SUM_W-2:0], ge};
    mag     = head_job.sum[wma_pkg::SUM_W-1] ? wma_pkg::SUM_W'(-head_job.sum)
                                             : wma_pkg::SUM_W'(head_job.sum);
    q16     = quo_r[wma_pkg::SAMPLE_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wma_pkg::DIV_IDLE: begin
        if (head_valid) state_nxt = wma_pkg::DIV_RUN;
      end
      wma_pkg::DIV_RUN: begin
        if (last_step) state_nxt = wma_pkg::DIV_DONE;
      end
      wma_pkg::DIV_DONE: begin
        if (!out_valid_r || pop) state_nxt = wma_pkg::DIV_IDLE;
      end
      default: state_nxt = wma_pkg::DIV_IDLE;
    endcase
  end

  always_comb begin
    head_pop = 1'b0;
    out_load = 1'b0;
    case (state_r)
      wma_pkg::DIV_IDLE: head_pop = head_valid;
      wma_pkg::DIV_DONE: out_load = !out_valid_r || pop;
      default: begin
        head_pop = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wma_pkg::DIV_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
      if (head_pop) begin
        step_r <= '0;
      end else if (state_r == wma_pkg::DIV_RUN) begin
        step_r <= step_r + wma_pkg::STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      quo_r <= mag;
      rem_r <= '0;
      div_r <= head_job.count;
      neg_r <= head_job.sum[wma_pkg::SUM_W-1];
    end else if (state_r == wma_pkg::DIV_RUN) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
    if (out_load) begin
      avg_r <= neg_r ? -q16 : q16;
    end
  end

  assign empty       = !out_valid_r;
  assign out_average = avg_r;

endmodule
`default_nettype wire

@@ src/windowed_moving_average.sv @@
// Top level of the windowed moving average: front part, job queue and divider.
// Depends on wma_pkg, wma_front, wma_queue and wma_back.
//
//   Channel   Ports                     Transfer when
//   input     push, full, in_sample     push && !full
//   result    empty, pop, out_average   pop && !empty
//   config    cfg_we, cfg_window_len    cfg_we
//
// The front part takes an item whenever the two-entry queue has room.
// The divider resolves one quotient bit a cycle and takes the next job from the queue
// only after it has handed its last result to the output register.
// Reset is synchronous; it sets the window length to five and empties the window.
// A stalled result waits in the output register; the divider may finish one more job, which
// then waits in the divider until the register frees, and the queue takes work while it has room.
`default_nettype none
module windowed_moving_average (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [wma_pkg::LEN_W-1:0]           cfg_window_len,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic signed [wma_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic signed [wma_pkg::SAMPLE_W-1:0]      out_average
);

  wma_pkg::wma_job_t new_job, head_job;
  logic              q_full, head_valid, head_pop, in_take;

  assign full    = q_full;
  assign in_take = push && !q_full;

  wma_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_window_len (cfg_window_len),
    .in_valid       (in_take),
    .in_sample      (in_sample),
    .job            (new_job)
  );

  wma_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (in_take),
    .wr_job     (new_job),
    .q_full     (q_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .rd_en      (head_pop)
  );

  wma_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head_job    (head_job),
    .head_pop    (head_pop),
    .empty       (empty),
    .pop         (pop),
    .out_average (out_average)
  );

endmodule
`default_nettype wire
